[rtl/gbm_pkg.sv]
// Package: shared constants, step codes, control structs and the 2^(i/8) table.
`default_nettype none
package gbm_pkg;

  localparam int ASSETS = 4;
  localparam int LANES  = (ASSETS < 4) ? ASSETS : 4;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [31:0] RECIP5    = 32'hCCCCCCCD;  // x/5 = (x*R)>>34 for 32-bit x
  localparam logic [31:0] RECIP3    = 32'hAAAAAAAB;  // x/3 = (x*R)>>33 for 32-bit x
  localparam logic [33:0] ONE_Q32   = 34'h1_0000_0000;

  // lane sequencer steps
  localparam logic [4:0] ST_PREP  = 5'd0;
  localparam logic [4:0] ST_MULDV = 5'd1;
  localparam logic [4:0] ST_SUMX  = 5'd2;
  localparam logic [4:0] ST_LOG2A = 5'd3;
  localparam logic [4:0] ST_LOG2B = 5'd4;
  localparam logic [4:0] ST_SPLIT = 5'd5;
  localparam logic [4:0] ST_H5    = 5'd6;
  localparam logic [4:0] ST_TQ4   = 5'd7;
  localparam logic [4:0] ST_H4    = 5'd8;
  localparam logic [4:0] ST_TQ3   = 5'd9;
  localparam logic [4:0] ST_H3    = 5'd10;
  localparam logic [4:0] ST_TQ2   = 5'd11;
  localparam logic [4:0] ST_H2    = 5'd12;
  localparam logic [4:0] ST_TQ1   = 5'd13;
  localparam logic [4:0] ST_H1    = 5'd14;
  localparam logic [4:0] ST_MANT  = 5'd15;
  localparam logic [4:0] ST_PROD  = 5'd16;
  localparam logic [4:0] ST_ROUND = 5'd17;
  localparam logic [4:0] ST_FINAL = 5'd18;

  typedef struct packed {
    logic       load;     // write price/mu/sigma
    logic       start;    // advance accepted: capture z, do prep step
    logic       step_en;
    logic [4:0] step;
  } lane_ctrl_t;

  typedef struct packed {
    logic strobe;  // capture prices into output register
    logic is_adv;
  } merge_ctrl_t;

  function automatic logic [30:0] pow2_eighth(input logic [2:0] idx);
    logic [30:0] v;
    unique case (idx)
      3'd0: v = 31'd1073741824;
      3'd1: v = 31'd1170923762;
      3'd2: v = 31'd1276901417;
      3'd3: v = 31'd1392470869;
      3'd4: v = 31'd1518500250;
      3'd5: v = 31'd1655936265;
      3'd6: v = 31'd1805811301;
      3'd7: v = 31'd1969251188;
      default: v = 31'd1073741824;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/gbm_lane.sv]
// One asset lane: stored parameters and a stepped exp/multiply datapath.
`default_nettype none
module gbm_lane (
  input  wire                  clk,
  input  wire                  rst,
  input  gbm_pkg::lane_ctrl_t  ctrl,
  input  wire  [31:0]          load_price,
  input  wire  [19:0]          load_mu,
  input  wire  [17:0]          load_sigma,
  input  wire  [15:0]          sample,
  input  wire  [23:0]          dt,
  input  wire  [23:0]          sqrt_dt,
  output logic [31:0]          price,
  output logic                 sat
);

  localparam logic signed [39:0] XCL = 40'sd103079215104;  // 24 * 2^32

  logic        [19:0] mu;
  logic        [17:0] sg;
  logic signed [15:0] z;
  logic signed [37:0] a;
  logic        [41:0] p1;
  logic signed [62:0] d;
  logic signed [58:0] vz;
  logic signed [37:0] x;
  logic               neg;
  logic        [62:0] plo;
  logic        [35:0] phi;
  logic signed [39:0] y;
  logic signed [7:0]  n;
  logic        [2:0]  idx;
  logic        [28:0] t;
  logic        [33:0] q;
  logic        [31:0] tq;
  logic        [31:0] m;
  logic        [63:0] prod;
  logic        [64:0] rs;
  logic signed [9:0]  s;

  // step combinational helpers
  logic        [35:0] sq;
  logic signed [64:0] sum;
  logic signed [39:0] xf;
  logic        [36:0] mag;
  logic        [38:0] ymag;
  logic        [60:0] tg;
  logic        [60:0] t5;
  logic        [62:0] tqp;
  logic        [63:0] t3;
  logic        [64:0] mp;
  logic signed [9:0]  s_n;
  logic        [64:0] rs_n;
  logic        [64:0] r65;
  logic        [9:0]  e;
  logic               ovf;
  logic        [31:0] r;

  always_comb begin
    sq   = 36'(sg) * 36'(sg);
    sum  = 65'(d) + (65'(vz) <<< 5) + 65'sd16777216;
    xf   = sum[64:25];
    mag  = x[37] ? 37'(-x) : 37'(x);
    ymag = 39'(plo[62:30]) + 39'({phi, 2'b00});
    tg   = 61'(y[28:0]) * 61'(gbm_pkg::LN2_Q32);
    t5   = 61'(t) * 61'(gbm_pkg::RECIP5);
    tqp  = 63'(t) * 63'(q);
    t3   = 64'(tq) * 64'(gbm_pkg::RECIP3);
    mp   = 65'(gbm_pkg::pow2_eighth(idx)) * 65'(q);
    s_n  = 10'sd30 - {{2{n[7]}}, n};
    if (s_n >= 10'sd1 && s_n <= 10'sd63) begin
      rs_n = {1'b0, prod} + (65'd1 << (6'(s_n) - 6'd1));
    end else begin
      rs_n = {1'b0, prod};
    end
    r65 = rs >> s[5:0];
    e   = 10'(-s);
    ovf = 1'b0;
    r   = 32'd0;
    if (s > 10'sd63) begin
      r = 32'd0;
    end else if (s >= 10'sd1) begin
      ovf = (r65 > 65'h0_FFFF_FFFF);
      r   = r65[31:0];
    end else begin
      ovf = (e >= 10'd32) || (prod > (64'hFFFF_FFFF >> e[4:0]));
      r   = 32'(prod << e[4:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      price <= '0;
      mu    <= '0;
      sg    <= '0;
      sat   <= 1'b0;
    end else if (ctrl.load) begin
      price <= load_price;
      mu    <= load_mu;
      sg    <= load_sigma;
    end else if (ctrl.start) begin
      z   <= sample;
      sat <= 1'b0;
      a   <= $signed({mu[19], mu, 17'd0}) - $signed({2'b00, sq});
      p1  <= 42'(sg) * 42'(sqrt_dt);
    end else if (ctrl.step_en) begin
      unique case (ctrl.step)
        gbm_pkg::ST_MULDV: begin
          d  <= a * $signed({1'b0, dt});
          vz <= $signed({1'b0, p1}) * z;
        end
        gbm_pkg::ST_SUMX: begin
          if (xf > XCL)       x <= 38'(XCL);
          else if (xf < -XCL) x <= 38'(-XCL);
          else                x <= 38'(xf);
        end
        gbm_pkg::ST_LOG2A: begin
          neg <= x[37];
          plo <= 63'(mag[31:0]) * 63'(gbm_pkg::LOG2E_Q30);
          phi <= 36'(mag[36:32]) * 36'(gbm_pkg::LOG2E_Q30);
        end
        gbm_pkg::ST_LOG2B: y <= neg ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
        gbm_pkg::ST_SPLIT: begin
          n   <= y[39:32];
          idx <= y[31:29];
          t   <= tg[60:32];
        end
        gbm_pkg::ST_H5:  q  <= gbm_pkg::ONE_Q32 + 34'(t5[60:34]);
        gbm_pkg::ST_TQ4,
        gbm_pkg::ST_TQ3,
        gbm_pkg::ST_TQ2,
        gbm_pkg::ST_TQ1: tq <= 32'(tqp[62:32]);
        gbm_pkg::ST_H4:  q  <= gbm_pkg::ONE_Q32 + 34'(tq[31:2]);
        gbm_pkg::ST_H3:  q  <= gbm_pkg::ONE_Q32 + 34'(t3[63:33]);
        gbm_pkg::ST_H2:  q  <= gbm_pkg::ONE_Q32 + 34'(tq[31:1]);
        gbm_pkg::ST_H1:  q  <= gbm_pkg::ONE_Q32 + 34'(tq);
        gbm_pkg::ST_MANT: m <= mp[63:32];
        gbm_pkg::ST_PROD: prod <= 64'(price) * 64'(m);
        gbm_pkg::ST_ROUND: begin
          rs <= rs_n;
          s  <= s_n;
        end
        gbm_pkg::ST_FINAL: begin
          price <= ovf ? 32'hFFFF_FFFF : r;
          sat   <= ovf;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/gbm_merge.sv]
// Merge stage: gathers lane prices and saturation into the output register.
`default_nettype none
module gbm_merge (
  input  wire                   clk,
  input  wire                   rst,
  input  gbm_pkg::merge_ctrl_t  ctrl,
  input  wire  [3:0][31:0]      lane_price,
  input  wire  [3:0]            lane_sat,
  output logic                  free,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [127:0]          m_axis_tdata,
  output logic [0:0]            m_axis_tuser
);

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.strobe) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.strobe) begin
      m_axis_tdata    <= lane_price;
      m_axis_tuser[0] <= ctrl.is_adv && (|lane_sat);
    end
  end

endmodule
`default_nettype wire

[rtl/gbm_price_path_step.sv]
// Top level: GBM one-step price update for a set of assets, lanes plus merge stage.
`default_nettype none
// Holds price, drift and volatility for each asset in its own lane. A transfer with
// tuser=0 loads one asset; with tuser=1 it advances every price by one exact GBM step
// using the four normal samples in tdata, then one result carrying all prices goes
// out. Overflowing prices clamp to all ones and set the saturated flag in tuser.
// A load writes its lane at the transfer, then its result waits for the output register.
// An advance does its prep step in the accept cycle and 18 more sequencer steps, then its
// result is captured into the output register. A new item is taken once the previous
// result sits in the output register. time_step (index 0) and sqrt_time_step (index 1)
// must be written only while idle; the block itself does not enforce this.
module gbm_price_path_step (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: asset_index[1:0], load_price[33:2], load_drift_rate[53:34],
  //        load_volatility[71:54], normal_sample_0..3 [87:72],[103:88],[119:104],[135:120]
  input  wire  [135:0] s_axis_tdata,
  // tuser: func
  input  wire  [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // tdata: price_0[31:0], price_1[63:32], price_2[95:64], price_3[127:96]
  output logic [127:0] m_axis_tdata,
  // tuser: saturated
  output logic [0:0]   m_axis_tuser,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [0:0]   cfg_index,
  input  wire  [23:0]  cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  localparam logic [0:0] REG_TIME_STEP = 1'd0;
  localparam logic [0:0] REG_SQRT_STEP = 1'd1;

  logic [1:0]  state;
  logic [4:0]  step;
  logic        is_adv;
  logic [23:0] time_step;
  logic [23:0] sqrt_time_step;
  logic        accept;
  logic        free;

  gbm_pkg::lane_ctrl_t  lctrl [4];
  gbm_pkg::merge_ctrl_t mctrl;
  logic [3:0][31:0]     lane_price;
  logic [3:0]           lane_sat;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= 24'd66576;
      sqrt_time_step <= 24'd1056898;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIME_STEP: time_step      <= cfg_data;
        REG_SQRT_STEP: sqrt_time_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= gbm_pkg::ST_PREP;
      is_adv <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (accept) begin
          is_adv <= s_axis_tuser[0];
          step   <= gbm_pkg::ST_MULDV;
          state  <= s_axis_tuser[0] ? S_RUN : S_WAIT;
        end
        S_RUN: begin
          step <= step + 5'd1;
          if (step == gbm_pkg::ST_FINAL) state <= S_WAIT;
        end
        S_WAIT: if (free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mctrl.strobe = (state == S_WAIT) && free;
  assign mctrl.is_adv = is_adv;

  for (genvar j = 0; j < 4; j++) begin : g_lane
    if (j < gbm_pkg::LANES) begin : g_on
      assign lctrl[j].load    = accept && !s_axis_tuser[0] && (s_axis_tdata[1:0] == 2'(j));
      assign lctrl[j].start   = accept && s_axis_tuser[0];
      assign lctrl[j].step_en = (state == S_RUN);
      assign lctrl[j].step    = step;
      gbm_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (lctrl[j]),
        .load_price (s_axis_tdata[33:2]),
        .load_mu    (s_axis_tdata[53:34]),
        .load_sigma (s_axis_tdata[71:54]),
        .sample     (s_axis_tdata[72+16*j +: 16]),
        .dt         (time_step),
        .sqrt_dt    (sqrt_time_step),
        .price      (lane_price[j]),
        .sat        (lane_sat[j])
      );
    end else begin : g_off
      // absent lane reads as zero
      assign lctrl[j]      = '0;
      assign lane_price[j] = 32'd0;
      assign lane_sat[j]   = 1'b0;
    end
  end

  gbm_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (mctrl),
    .lane_price    (lane_price),
    .lane_sat      (lane_sat),
    .free          (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire

[rtl/gbm_checker.sv]
// Port checker for the GBM step block, bound to the top level.
`default_nettype none
module gbm_checker (
  input wire         clk,
  input wire         rst,
  input wire         s_axis_tvalid,
  input wire         s_axis_tready,
  input wire [135:0] s_axis_tdata,
  input wire [0:0]   s_axis_tuser,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [127:0] m_axis_tdata,
  input wire [0:0]   m_axis_tuser,
  input wire         cfg_valid,
  input wire         cfg_ready,
  input wire [0:0]   cfg_index,
  input wire [23:0]  cfg_data
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transfer taken while busy");

  // saturated needs a clamped price
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[31:0] == 32'hFFFF_FFFF) || (m_axis_tdata[63:32] == 32'hFFFF_FFFF) ||
      (m_axis_tdata[95:64] == 32'hFFFF_FFFF) || (m_axis_tdata[127:96] == 32'hFFFF_FFFF))
    else $error("saturated without clamped price");

  // no result right out of reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind gbm_price_path_step gbm_checker u_gbm_checker (.*);
`default_nettype wire
